@@ sv/utf8wa_pkg.sv @@
// Package for the UTF-8 / WinAnsi validator.
// Holds the decode constants and the WinAnsi membership check; no dependencies.
package utf8wa_pkg;

    // Lead byte ranges
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;

    // Continuation byte form 10xxxxxx
    localparam logic [1:0] CONT_TAG = 2'b10;

    // Codepoint limits
    localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;
    localparam logic [15:0] SURR_MIN       = 16'hD800;
    localparam logic [15:0] SURR_MAX       = 16'hDFFF;

    // Continuation bytes still expected
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    // True when the codepoint can be written in WinAnsi
    function automatic logic in_winansi(input logic [15:0] cp);
        logic hit;
        hit = 1'b0;
        if (cp >= 16'h0020 && cp <= 16'h007E) hit = 1'b1;
        if (cp >= 16'h00A0 && cp <= 16'h00FF) hit = 1'b1;
        if (cp >= 16'h2013 && cp <= 16'h2026) hit = 1'b1;
        case (cp)
            16'h0009, 16'h000A, 16'h000D, 16'h20AC,
            16'h0192, 16'h02C6, 16'h02DC, 16'h0152, 16'h0153,
            16'h0160, 16'h0161, 16'h0178, 16'h017D, 16'h017E,
            16'h2030, 16'h2039, 16'h203A, 16'h2122: hit = 1'b1;
            default: ;
        endcase
        return hit;
    endfunction

endpackage

@@ sv/utf8_winansi_validator.sv @@
// Top level of the UTF-8 / WinAnsi validator: byte decoder and verdict register.
// Depends on utf8wa_pkg.
//
// Takes one byte per cycle while the verdict register is empty or being drained,
// and returns one verdict for each terminator transaction: 1 when the text since
// the last terminator was valid UTF-8 (one to three byte sequences) and every
// codepoint lies in the WinAnsi set. The decode state is updated at the accept
// edge and a verdict shows on m_valid the cycle after its terminator. The single
// verdict register sets the rate: input is taken whenever that register is
// empty or being drained, so a full stream runs at one byte per cycle.
module utf8_winansi_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_is_terminator,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_representable
);
    import utf8wa_pkg::*;

    logic [1:0]  pend_reg,  pend_next;
    logic [15:0] cp_reg,    cp_next;
    logic        three_reg, three_next;
    logic        err_reg,   err_next;
    logic        m_valid_reg, m_valid_next;
    logic        rep_reg,   rep_next;

    logic        s_acc;
    logic [15:0] cp_join;
    logic [1:0]  pend_dec;
    logic        finish_bad;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_acc   = s_valid && s_ready;

    // Shift in the six payload bits of a continuation byte
    assign cp_join  = {cp_reg[9:0], s_text_byte[5:0]};
    assign pend_dec = pend_reg - PEND_ONE;

    // Check a completed multi-byte codepoint
    always_comb begin
        if (three_reg && cp_join < THREE_BYTE_MIN) begin
            finish_bad = 1'b1;
        end else if (cp_join >= SURR_MIN && cp_join <= SURR_MAX) begin
            finish_bad = 1'b1;
        end else begin
            finish_bad = !in_winansi(cp_join);
        end
    end

    // Decode the accepted transaction
    always_comb begin
        pend_next    = pend_reg;
        cp_next      = cp_reg;
        three_next   = three_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_ready;
        rep_next     = rep_reg;
        if (s_acc) begin
            if (s_is_terminator) begin
                m_valid_next = 1'b1;
                rep_next     = !err_reg && (pend_reg == PEND_NONE);
                pend_next    = PEND_NONE;
                cp_next      = '0;
                three_next   = 1'b0;
                err_next     = 1'b0;
            end else if (!err_reg) begin
                if (pend_reg == PEND_NONE) begin
                    if (!s_text_byte[7]) begin
                        err_next = !in_winansi({8'h00, s_text_byte});
                    end else if (s_text_byte >= LEAD2_MIN && s_text_byte <= LEAD2_MAX) begin
                        cp_next    = {11'd0, s_text_byte[4:0]};
                        pend_next  = PEND_ONE;
                        three_next = 1'b0;
                    end else if (s_text_byte >= LEAD3_MIN && s_text_byte <= LEAD3_MAX) begin
                        cp_next    = {12'd0, s_text_byte[3:0]};
                        pend_next  = PEND_TWO;
                        three_next = 1'b1;
                    end else begin
                        err_next = 1'b1;
                    end
                end else if (s_text_byte[7:6] != CONT_TAG) begin
                    err_next  = 1'b1;
                    pend_next = PEND_NONE;
                end else begin
                    pend_next = pend_dec;
                    if (pend_dec == PEND_NONE) begin
                        err_next   = finish_bad;
                        cp_next    = '0;
                        three_next = 1'b0;
                    end else begin
                        cp_next = cp_join;
                    end
                end
            end
        end
    end

    // Hold decode state and the verdict register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= PEND_NONE;
            cp_reg      <= '0;
            three_reg   <= 1'b0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            cp_reg      <= cp_next;
            three_reg   <= three_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        rep_reg <= rep_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_representable = rep_reg;

endmodule

@@ sv/utf8wa_checker.sv @@
// Port-level checker for the UTF-8 / WinAnsi validator, bound to the top level.
// Depends on utf8_winansi_validator's port list.
module utf8wa_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_text_byte,
    input logic       s_is_terminator,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_representable
);
    logic s_acc;
    logic term_acc;
    assign s_acc    = s_valid && s_ready;
    assign term_acc = s_acc && s_is_terminator;

    // Hold a stalled verdict
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_representable))
        else $error("verdict dropped or changed while stalled");

    // Every terminator gives a verdict next cycle
    a_term_result: assert property (@(posedge aclk) disable iff (!aresetn)
        term_acc |=> m_valid)
        else $error("terminator gave no verdict");

    // No verdict without a terminator
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) && !term_acc |=> !m_valid)
        else $error("verdict without terminator");

    // Empty text is representable
    a_empty_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        term_acc ##1 term_acc |=> m_representable)
        else $error("empty text rejected");

    // A zero data byte followed by a terminator is rejected
    a_zero_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_is_terminator && s_text_byte == 8'h00) ##1 term_acc
        |=> !m_representable)
        else $error("zero data byte accepted");

endmodule

bind utf8_winansi_validator utf8wa_checker u_utf8wa_checker (.*);

@@ tb/utf8wa_verdict_checker.sv @@
// Verdict checker for the UTF-8 / WinAnsi validator testbench.
// Depends on utf8wa_pkg; watches both channels, predicts each verdict and compares it.
module utf8wa_verdict_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_is_terminator,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_representable,
    output int         mismatches,
    output int         verdicts_outstanding
);
    import utf8wa_pkg::*;

    // Predicted decode state
    logic [1:0]  cp_pending;
    logic [15:0] cp_acc;
    logic        cp_long;
    logic        cp_bad;

    logic        verdict_q[$];
    logic        want_rep;
    int          err_count;

    initial begin
        err_count = 0;
    end

    // Membership in the WinAnsi-writable codepoint set
    function automatic logic winansi_member(input logic [15:0] cp);
        if (cp == 16'h0009 || cp == 16'h000A || cp == 16'h000D) return 1'b1;
        if (cp >= 16'h0020 && cp <= 16'h007E) return 1'b1;
        if (cp >= 16'h00A0 && cp <= 16'h00FF) return 1'b1;
        if (cp == 16'h0152 || cp == 16'h0153 || cp == 16'h0160 || cp == 16'h0161)
            return 1'b1;
        if (cp == 16'h0178 || cp == 16'h017D || cp == 16'h017E) return 1'b1;
        if (cp == 16'h0192 || cp == 16'h02C6 || cp == 16'h02DC) return 1'b1;
        if (cp >= 16'h2013 && cp <= 16'h2026) return 1'b1;
        if (cp == 16'h2030 || cp == 16'h2039 || cp == 16'h203A) return 1'b1;
        if (cp == 16'h20AC || cp == 16'h2122) return 1'b1;
        return 1'b0;
    endfunction

    // Reject overlong three-byte forms and surrogates, then check the set
    function automatic logic codepoint_ok(input logic [15:0] cp, input logic long_form);
        if (long_form && cp < THREE_BYTE_MIN) return 1'b0;
        if (cp >= SURR_MIN && cp <= SURR_MAX) return 1'b0;
        return winansi_member(cp);
    endfunction

    // Advance the predicted decoder by one text byte
    task automatic decode_byte(input logic [7:0] b);
        if (cp_bad) return;
        if (cp_pending == PEND_NONE) begin
            if (b[7] == 1'b0) begin
                if (!codepoint_ok({8'h00, b}, 1'b0)) cp_bad = 1'b1;
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
                cp_acc     = {11'd0, b[4:0]};
                cp_pending = PEND_ONE;
                cp_long    = 1'b0;
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
                cp_acc     = {12'd0, b[3:0]};
                cp_pending = PEND_TWO;
                cp_long    = 1'b1;
            end else begin
                cp_bad = 1'b1;
            end
        end else if (b[7:6] != CONT_TAG) begin
            cp_bad     = 1'b1;
            cp_pending = PEND_NONE;
        end else begin
            cp_acc     = {cp_acc[9:0], b[5:0]};
            cp_pending = cp_pending - PEND_ONE;
            if (cp_pending == PEND_NONE) begin
                if (!codepoint_ok(cp_acc, cp_long)) cp_bad = 1'b1;
                cp_acc  = 16'h0000;
                cp_long = 1'b0;
            end
        end
    endtask

    // Compare delivered verdicts first, then absorb the input transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            cp_pending = PEND_NONE;
            cp_acc     = 16'h0000;
            cp_long    = 1'b0;
            cp_bad     = 1'b0;
            verdict_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("representable: expected none, actual %0d", m_representable);
                    err_count++;
                end else begin
                    want_rep = verdict_q.pop_front();
                    if (want_rep !== m_representable) begin
                        $error("representable: expected %0d, actual %0d",
                               want_rep, m_representable);
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_is_terminator) begin
                    verdict_q.push_back(!cp_bad && cp_pending == PEND_NONE);
                    cp_pending = PEND_NONE;
                    cp_acc     = 16'h0000;
                    cp_long    = 1'b0;
                    cp_bad     = 1'b0;
                end else begin
                    decode_byte(s_text_byte);
                end
            end
        end
        mismatches           <= err_count;
        verdicts_outstanding <= verdict_q.size();
    end

endmodule

@@ tb/tb.sv @@
// Top of the UTF-8 / WinAnsi validator testbench: clock, reset, stimulus and verdict.
// Depends on utf8wa_pkg, utf8_winansi_validator and utf8wa_verdict_checker.
module tb;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte     = 8'h00;
    logic       s_is_terminator = 1'b0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_representable;

    int mismatches;
    int verdicts_outstanding;
    int items_sent = 0;
    bit tx_calm    = 1'b0;

    // Bit 8 marks a terminator, bits 7:0 carry the byte
    logic [8:0] item_q[$];

    localparam logic [15:0] SPECIAL_CPS [0:14] = '{
        16'h0152, 16'h0153, 16'h0160, 16'h0161, 16'h0178, 16'h017D, 16'h017E,
        16'h0192, 16'h02C6, 16'h02DC, 16'h2030, 16'h2039, 16'h203A, 16'h20AC,
        16'h2122
    };

    utf8_winansi_validator uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .s_is_terminator (s_is_terminator),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_representable (m_representable)
    );

    utf8wa_verdict_checker verdict_chk (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_text_byte          (s_text_byte),
        .s_is_terminator      (s_is_terminator),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_representable      (m_representable),
        .mismatches           (mismatches),
        .verdicts_outstanding (verdicts_outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic add_byte(input logic [7:0] b);
        item_q.push_back({1'b0, b});
    endtask

    // Terminator byte content is ignored, so randomize it
    task automatic add_term();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        item_q.push_back({1'b1, junk});
    endtask

    // Encode a codepoint; long_form forces the three-byte form
    task automatic add_cp(input logic [15:0] cp, input logic long_form);
        if (!long_form && cp < 16'h0080) begin
            add_byte(cp[7:0]);
        end else if (!long_form && cp < 16'h0800) begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
        end else begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
    endtask

    // Build one random text: mostly well-formed, some with errors or truncation
    task automatic make_text();
        int         n;
        int         kind;
        logic       dirty;
        logic [7:0] b;
        logic [15:0] cp;
        dirty = ($urandom_range(0, 9) < 3);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            kind = dirty ? $urandom_range(0, 10) : $urandom_range(0, 3);
            case (kind)
                0: add_cp(16'($urandom_range(16'h20, 16'h7E)), 1'b0);
                1: begin
                    case ($urandom_range(0, 2))
                        0: add_byte(8'h09);
                        1: add_byte(8'h0A);
                        default: add_byte(8'h0D);
                    endcase
                end
                2: add_cp(16'($urandom_range(16'hA0, 16'hFF)), 1'b0);
                3: begin
                    if ($urandom_range(0, 2) == 0)
                        add_cp(16'($urandom_range(16'h2013, 16'h2026)), 1'b0);
                    else
                        add_cp(SPECIAL_CPS[4'($urandom_range(0, 14))], 1'b0);
                end
                4: add_cp(16'($urandom_range(16'h80, 16'h7FF)), 1'b0);
                5: add_cp(16'($urandom_range(16'h800, 16'hFFFF)), 1'b0);
                6: add_cp(16'($urandom_range(0, 16'h7FF)), 1'b1);
                7: add_byte(8'($urandom_range(0, 255)));
                8: begin
                    // lead byte followed by a byte that is not a continuation
                    add_byte(8'($urandom_range(8'hC2, 8'hEF)));
                    b = 8'($urandom_range(0, 255));
                    if (b[7:6] == 2'b10) b[6] = 1'b1;
                    add_byte(b);
                end
                9: add_cp(16'($urandom_range(16'hD800, 16'hDFFF)), 1'b1);
                default: begin
                    cp = 16'($urandom_range(0, 32));
                    add_cp((cp == 16'd32) ? 16'h007F : cp, 1'b0);
                end
            endcase
        end
        // drop the tail byte now and then to cut a sequence short
        if (dirty && item_q.size() > 0 && $urandom_range(0, 2) == 0)
            void'(item_q.pop_back());
        add_term();
    endtask

    // Present one transaction after a random gap and hold it until accepted
    task automatic send_item(input logic [8:0] item);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_text_byte     <= item[7:0];
        s_is_terminator <= item[8];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain_items();
        tx_calm = ($urandom_range(0, 4) == 0);
        while (item_q.size() > 0) send_item(item_q.pop_front());
    endtask

    // Result side: random stall per verdict, with stretches of no stalling
    initial begin
        int gap;
        int stretch;
        bit calm;
        stretch = 0;
        calm    = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (stretch == 0) begin
                stretch = $urandom_range(4, 20);
                calm    = ($urandom_range(0, 3) == 0);
            end
            stretch--;
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty text
        add_term();
        // Tab, top of printable ASCII and the euro sign: valid
        add_byte(8'h09);
        add_byte(8'h7E);
        add_cp(16'h20AC, 1'b0);
        add_term();
        // Zero byte as data
        add_byte(8'h00);
        add_term();
        // Rejected lead just below the two-byte range
        add_byte(8'hC1);
        add_term();
        // Bad continuation
        add_byte(8'hC2);
        add_byte(8'h41);
        add_term();
        // Overlong three-byte form
        add_byte(8'hE0);
        add_byte(8'h80);
        add_byte(8'h80);
        add_term();
        // Surrogate
        add_byte(8'hED);
        add_byte(8'hA0);
        add_byte(8'h80);
        add_term();
        // Truncated sequence
        add_byte(8'hE2);
        add_byte(8'h82);
        add_term();
        drain_items();

        while (items_sent < 1300) begin
            make_text();
            drain_items();
        end
        s_valid <= 1'b0;

        // Let the last push land, then wait for every verdict and a short tail
        @(posedge aclk);
        while (verdicts_outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hold a hard limit on run length
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
